@@ rtl/core/lppd_pkg.sv @@
package lppd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned FieldW  = 16;
	localparam int unsigned StatusW = 2;

	localparam logic [FieldW-1:0] MaxPayloadReset = 16'd4092;

	typedef enum logic [StatusW-1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_OVERSIZE = 2'd2
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [ByteW-1:0]    payload_byte;
		logic [FieldW-1:0]   packet_type;
		logic [FieldW-1:0]   packet_size;
		logic                last;
	} result_t;

endpackage

@@ rtl/core/length_prefixed_packet_deframer_core.sv @@
// length-prefixed packet deframer
//
// in channel: one stream byte per request (in_byte), taken at a clock edge with
// in_valid high and in_stall low. each packet is a 4-byte header (16-bit size,
// then 16-bit type, both little-endian) followed by size payload bytes.
// out channel: one result per payload byte (status payload), one empty-packet
// result for a zero-size header, or one oversize result when the size exceeds
// max_payload, after which that payload is consumed silently. last marks the
// final result of a packet. a result is taken when out_valid is high and
// out_stall is low.
// each result is registered and reaches the outputs through the output register.
// throughput: one byte per cycle, set by the single registered update of the
// header/payload state; the output register plus a one-entry skid register
// keep in_stall a registered signal, so input is held off only once both are
// full under a stalled receiver.
// max_payload is written through max_payload_we / max_payload_wdata and is
// compared when a header completes.
// reset (arst_n low) returns to awaiting a header, empties the output and skid
// registers and loads max_payload with 4092.
module length_prefixed_packet_deframer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           max_payload_we,
	input  logic [lppd_pkg::FieldW-1:0]    max_payload_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lppd_pkg::ByteW-1:0]     in_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lppd_pkg::StatusW-1:0]   status,
	output logic [lppd_pkg::ByteW-1:0]     payload_byte,
	output logic [lppd_pkg::FieldW-1:0]    packet_type,
	output logic [lppd_pkg::FieldW-1:0]    packet_size,
	output logic                           last
);

	logic [lppd_pkg::FieldW-1:0] max_payload_q;
	logic [1:0]                  hdr_idx_q;
	logic                        in_payload_q;
	logic                        dropping_q;
	logic [lppd_pkg::FieldW-1:0] size_q;
	logic [lppd_pkg::FieldW-1:0] type_q;
	logic [lppd_pkg::FieldW-1:0] bytes_left_q;

	logic [1:0]                  hdr_idx_d;
	logic                        in_payload_d;
	logic                        dropping_d;
	logic [lppd_pkg::FieldW-1:0] size_d;
	logic [lppd_pkg::FieldW-1:0] type_d;
	logic [lppd_pkg::FieldW-1:0] bytes_left_d;
	logic [lppd_pkg::FieldW-1:0] bytes_left_dec;

	logic                        accept;
	logic                        res_valid;
	lppd_pkg::result_t           res;

	logic                        out_valid_q;
	lppd_pkg::result_t           out_q;
	logic                        skid_valid_q;
	lppd_pkg::result_t           skid_q;
	logic                        load_out;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid & ~skid_valid_q;
	assign bytes_left_dec = bytes_left_q - 16'd1;

	always_comb begin
		hdr_idx_d        = hdr_idx_q;
		in_payload_d     = in_payload_q;
		dropping_d       = dropping_q;
		size_d           = size_q;
		type_d           = type_q;
		bytes_left_d     = bytes_left_q;
		res_valid        = 1'b0;
		res.status       = lppd_pkg::ST_PAYLOAD;
		res.payload_byte = '0;
		res.last         = 1'b0;
		if (in_payload_q) begin
			bytes_left_d = bytes_left_dec;
			if (bytes_left_dec == '0) begin
				in_payload_d = 1'b0;
				hdr_idx_d    = 2'd0;
				dropping_d   = 1'b0;
			end
			if (!dropping_q) begin
				res_valid        = 1'b1;
				res.payload_byte = in_byte;
				res.last         = (bytes_left_dec == '0);
			end
		end else begin
			case (hdr_idx_q)
				2'd0: size_d = {size_q[15:8], in_byte};
				2'd1: size_d = {in_byte, size_q[7:0]};
				2'd2: type_d = {type_q[15:8], in_byte};
				default: type_d = {in_byte, type_q[7:0]};
			endcase
			if (hdr_idx_q != 2'd3) begin
				hdr_idx_d = hdr_idx_q + 2'd1;
			end else begin
				hdr_idx_d = 2'd0;
				// header complete: size_q already holds both size bytes
				if (size_q == '0) begin
					res_valid  = 1'b1;
					res.status = lppd_pkg::ST_EMPTY;
					res.last   = 1'b1;
				end else begin
					in_payload_d = 1'b1;
					bytes_left_d = size_q;
					dropping_d   = (size_q > max_payload_q);
					if (size_q > max_payload_q) begin
						res_valid  = 1'b1;
						res.status = lppd_pkg::ST_OVERSIZE;
						res.last   = 1'b1;
					end
				end
			end
		end
		res.packet_type = type_d;
		res.packet_size = size_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= lppd_pkg::MaxPayloadReset;
			hdr_idx_q     <= 2'd0;
			in_payload_q  <= 1'b0;
			dropping_q    <= 1'b0;
			size_q        <= '0;
			type_q        <= '0;
			bytes_left_q  <= '0;
		end else begin
			if (max_payload_we) begin
				max_payload_q <= max_payload_wdata;
			end
			if (accept) begin
				hdr_idx_q    <= hdr_idx_d;
				in_payload_q <= in_payload_d;
				dropping_q   <= dropping_d;
				size_q       <= size_d;
				type_q       <= type_d;
				bytes_left_q <= bytes_left_d;
			end
		end
	end

	// output register with one skid entry behind it
	assign load_out = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept & res_valid;
			end
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign payload_byte = out_q.payload_byte;
	assign packet_type  = out_q.packet_type;
	assign packet_size  = out_q.packet_size;
	assign last         = out_q.last;

endmodule

@@ dv/lppd_deframe_checker.sv @@
`timescale 1ns / 100ps

module lppd_deframe_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           max_payload_we,
	input  logic [lppd_pkg::FieldW-1:0]    max_payload_wdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [lppd_pkg::ByteW-1:0]     in_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [lppd_pkg::StatusW-1:0]   status,
	input  logic [lppd_pkg::ByteW-1:0]     payload_byte,
	input  logic [lppd_pkg::FieldW-1:0]    packet_type,
	input  logic [lppd_pkg::FieldW-1:0]    packet_size,
	input  logic                           last,
	output int unsigned                    mismatch_count,
	output int unsigned                    outstanding
);

	logic [1:0]                  hdr_pos;
	logic                        in_body;
	logic                        discarding;
	logic [lppd_pkg::FieldW-1:0] size_q;
	logic [lppd_pkg::FieldW-1:0] type_q;
	logic [lppd_pkg::FieldW-1:0] remaining;
	logic [lppd_pkg::FieldW-1:0] limit_q;
	lppd_pkg::result_t           deframed_q[$];

	task automatic push_result(input lppd_pkg::status_t st,
			input logic [lppd_pkg::ByteW-1:0] b, input logic lst);
		lppd_pkg::result_t r;
		r.status = st;
		r.payload_byte = b;
		r.packet_type = type_q;
		r.packet_size = size_q;
		r.last = lst;
		deframed_q.push_back(r);
	endtask

	task automatic deframe_byte(input logic [lppd_pkg::ByteW-1:0] b);
		if (in_body) begin
			remaining = remaining - 1'b1;
			if (remaining == '0) begin
				in_body = 1'b0;
				hdr_pos = '0;
			end
			if (discarding) begin
				if (!in_body)
					discarding = 1'b0;
			end else begin
				push_result(lppd_pkg::ST_PAYLOAD, b, !in_body);
			end
		end else begin
			// header: size lo, size hi, type lo, type hi
			case (hdr_pos)
				2'd0: size_q[7:0] = b;
				2'd1: size_q[15:8] = b;
				2'd2: type_q[7:0] = b;
				default: type_q[15:8] = b;
			endcase
			if (hdr_pos != 2'd3) begin
				hdr_pos = hdr_pos + 1'b1;
			end else begin
				hdr_pos = '0;
				if (size_q == '0) begin
					push_result(lppd_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					in_body = 1'b1;
					remaining = size_q;
					discarding = (size_q > limit_q);
					if (discarding)
						push_result(lppd_pkg::ST_OVERSIZE, '0, 1'b1);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	task automatic check_result();
		lppd_pkg::result_t e;
		if (deframed_q.size() == 0) begin
			$display("%0t: unexpected result: status %0d byte 0x%0h type 0x%0h size 0x%0h last %0b",
				$time, status, payload_byte, packet_type, packet_size, last);
			mismatch_count++;
		end else begin
			e = deframed_q.pop_front();
			check_field("status", 32'(e.status), 32'(status));
			check_field("payload_byte", 32'(e.payload_byte), 32'(payload_byte));
			check_field("packet_type", 32'(e.packet_type), 32'(packet_type));
			check_field("packet_size", 32'(e.packet_size), 32'(packet_size));
			check_field("last", 32'(e.last), 32'(last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos = '0;
			in_body = 1'b0;
			discarding = 1'b0;
			size_q = '0;
			type_q = '0;
			remaining = '0;
			limit_q = lppd_pkg::MaxPayloadReset;
			deframed_q.delete();
		end else begin
			// results leave before new requests are predicted in the same cycle
			if (out_valid && !out_stall)
				check_result();
			if (max_payload_we)
				limit_q = max_payload_wdata;
			if (in_valid && !in_stall)
				deframe_byte(in_byte);
		end
		outstanding = deframed_q.size();
	end

endmodule

@@ dv/tb_length_prefixed_packet_deframer_core.sv @@
`timescale 1ns / 100ps

module tb_length_prefixed_packet_deframer_core;

	localparam int unsigned QuietLimit = 4000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          max_payload_we = 1'b0;
	logic [lppd_pkg::FieldW-1:0]   max_payload_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [lppd_pkg::ByteW-1:0]    in_byte = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [lppd_pkg::StatusW-1:0]  status;
	logic [lppd_pkg::ByteW-1:0]    payload_byte;
	logic [lppd_pkg::FieldW-1:0]   packet_type;
	logic [lppd_pkg::FieldW-1:0]   packet_size;
	logic                          last;
	int unsigned                   mismatch_count;
	int unsigned                   outstanding;

	int unsigned                   tx_pct = 0;
	int unsigned                   rx_pct = 0;
	logic [lppd_pkg::FieldW-1:0]   cur_max = lppd_pkg::MaxPayloadReset;
	int unsigned                   quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	length_prefixed_packet_deframer_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.max_payload_we    (max_payload_we),
		.max_payload_wdata (max_payload_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.in_byte           (in_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.payload_byte      (payload_byte),
		.packet_type       (packet_type),
		.packet_size       (packet_size),
		.last              (last)
	);

	lppd_deframe_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.max_payload_we    (max_payload_we),
		.max_payload_wdata (max_payload_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.in_byte           (in_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.payload_byte      (payload_byte),
		.packet_type       (packet_type),
		.packet_size       (packet_size),
		.last              (last),
		.mismatch_count    (mismatch_count),
		.outstanding       (outstanding)
	);

	always @(posedge clk) begin
		out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || max_payload_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QuietLimit)
			@(posedge clk);
		$display("%0t: no request accepted for %0d cycles", $time, QuietLimit);
		$display("** length_prefixed_packet_deframer_core: FAILED **");
		$finish;
	end

	// called at a rising edge; returns at the edge where the byte is taken
	task automatic send_byte(input logic [lppd_pkg::ByteW-1:0] b);
		logic stalled;
		// each idle cycle is drawn on its own
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic send_header(input logic [lppd_pkg::FieldW-1:0] sz,
			input logic [lppd_pkg::FieldW-1:0] ptype);
		send_byte(sz[7:0]);
		send_byte(sz[15:8]);
		send_byte(ptype[7:0]);
		send_byte(ptype[15:8]);
	endtask

	task automatic send_packet(input logic [lppd_pkg::FieldW-1:0] sz,
			input logic [lppd_pkg::FieldW-1:0] ptype);
		send_header(sz, ptype);
		for (int unsigned i = 0; i < sz; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	// hold the sender until every predicted result is out, then let the pipe settle
	task automatic drain_outputs();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max(input logic [lppd_pkg::FieldW-1:0] v);
		drain_outputs();
		max_payload_we <= 1'b1;
		max_payload_wdata <= v;
		@(posedge clk);
		max_payload_we <= 1'b0;
		cur_max = v;
		@(posedge clk);
	endtask

	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 0;
		// sizes around a small limit: one below, equal, one above
		if (r < 30 && cur_max <= 64)
			return (cur_max == 0) ? $urandom_range(1) : cur_max - 1 + $urandom_range(2);
		if (r < 75)
			return $urandom_range(1, 8);
		return $urandom_range(9, 40);
	endfunction

	task automatic random_packets(input int unsigned n);
		int unsigned sent;
		int unsigned sz;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 2)
				drain_outputs();
			sz = pick_size();
			send_packet(sz[15:0], 16'($urandom_range(65535)));
			sent += sz + 4;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_pct = 11;
		rx_pct = 77;

		// reset limit: empty packet, then one byte
		send_header(16'h0000, 16'hFFFF);
		send_header(16'h0001, 16'h0000);
		send_byte(8'hFF);

		// size equal to the limit is accepted
		set_max(16'd2);
		send_header(16'h0002, 16'h8001);
		send_byte(8'h00);
		send_byte(8'h80);

		// limit changed mid-packet only affects the next header
		send_header(16'h0002, 16'h7FFE);
		send_byte(8'h5A);
		set_max(16'd0);
		send_byte(8'hA5);
		send_header(16'h0001, 16'h1234);
		send_byte(8'h3C);

		set_max(16'd16);
		random_packets(100);
		set_max(16'd0);
		random_packets(130);

		drain_outputs();
		tx_pct = 77;
		rx_pct = 11;
		set_max(16'd7);
		random_packets(100);
		set_max(16'hFFFF);
		send_packet(16'h0123, 16'hC3A5);
		random_packets(50);

		drain_outputs();
		tx_pct = 0;
		rx_pct = 0;
		set_max(16'd3);
		random_packets(100);
		set_max(16'h00FF);
		send_packet(16'h0100, 16'h0F0F);
		random_packets(50);

		drain_outputs();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("** length_prefixed_packet_deframer_core: PASSED **");
		end else begin
			if (outstanding != 0)
				$display("%0t: %0d results never arrived", $time, outstanding);
			$display("** length_prefixed_packet_deframer_core: FAILED **");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/lppd_pkg.sv
rtl/core/length_prefixed_packet_deframer_core.sv
dv/lppd_deframe_checker.sv
dv/tb_length_prefixed_packet_deframer_core.sv
